// File: sv/contiguous_first_fit_allocator_unit_assert.svh
// Assertion macros for the contiguous first-fit allocator.
`ifndef CONTIGUOUS_FIRST_FIT_ALLOCATOR_UNIT_ASSERT_SVH
`define CONTIGUOUS_FIRST_FIT_ALLOCATOR_UNIT_ASSERT_SVH

// Same-cycle implication, sampled on clock and disabled during reset.
`define CFFA_ASSERT_NOW(label, cond, prop) \
   label: assert property (@(posedge clock) disable iff (reset) (cond) |-> (prop)) \
      else $error("allocator check failed");

// Next-cycle implication, sampled on clock and disabled during reset.
`define CFFA_ASSERT_NEXT(label, cond, prop) \
   label: assert property (@(posedge clock) disable iff (reset) (cond) |=> (prop)) \
      else $error("allocator check failed");

`endif

// File: sv/cffa_pkg.sv
// Shared types and constants for the contiguous first-fit allocator.
`default_nettype none

package cffa_pkg;

   localparam int MAX_BLOCKS_DEF = 256;

   localparam int SIZE_W    = 24;
   localparam int BS_W      = 16;
   localparam int BC_W      = 9;
   localparam int START_W   = 8;
   localparam int DIV_CNT_W = 5;

   localparam int CSR_IDX_W  = 8;
   localparam int CSR_DATA_W = 16;

   localparam logic [CSR_IDX_W-1:0] CSR_BLOCK_SIZE  = CSR_IDX_W'(0);
   localparam logic [CSR_IDX_W-1:0] CSR_BLOCK_COUNT = CSR_IDX_W'(1);

   localparam logic [BS_W-1:0] BLOCK_SIZE_RST  = BS_W'(1);
   localparam logic [BC_W-1:0] BLOCK_COUNT_RST = BC_W'(256);

   typedef enum logic [2:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_DIV,
      ST_NEED,
      ST_SCAN,
      ST_MARK,
      ST_RESULT
   } state_type;

endpackage

`default_nettype wire

// File: sv/cffa_channels.sv
// Valid/ready channel interfaces for request, response and register writes.
`default_nettype none

interface cffa_req_if;
   logic                          valid;
   logic                          ready;
   logic [cffa_pkg::SIZE_W-1:0]   file_size;

   modport source (output valid, output file_size, input ready);
   modport sink   (input valid, input file_size, output ready);
endinterface

interface cffa_rsp_if;
   logic                          valid;
   logic                          ready;
   logic                          status;
   logic [cffa_pkg::START_W-1:0]  start_block;
   logic [cffa_pkg::SIZE_W-1:0]   blocks_needed;

   modport source (output valid, output status, output start_block,
                   output blocks_needed, input ready);
   modport sink   (input valid, input status, input start_block,
                   input blocks_needed, output ready);
endinterface

interface cffa_csr_if;
   logic                             valid;
   logic                             ready;
   logic [cffa_pkg::CSR_IDX_W-1:0]   index;
   logic [cffa_pkg::CSR_DATA_W-1:0]  data;

   modport source (output valid, output index, output data, input ready);
   modport sink   (input valid, input index, input data, output ready);
endinterface

`default_nettype wire

// File: sv/contiguous_first_fit_allocator_unit.sv
// Contiguous first-fit block allocator with bit-serial divider and map scan.
//
//   Channel    Direction  Contents
//   req_chan   in         file_size
//   rsp_chan   out        status, start_block, blocks_needed
//   csr_chan   in         index, data (block_size, block_count)
//
// A request runs a one-bit-per-cycle divide, then, unless the block count is zero
// or over the usable blocks, a map scan (one map bit read per cycle), then marks
// each granted block in the map, and then loads the response register.
// After reset, a clearing pass over all MAX_BLOCKS map entries empties the map
// before the first request transfer; register writes are taken throughout.
// A new request is taken while the previous response waits for its transfer.
`default_nettype none

module contiguous_first_fit_allocator_unit #(
   parameter int MAX_BLOCKS = cffa_pkg::MAX_BLOCKS_DEF
) (
   input  wire logic   clock,
   input  wire logic   reset,
   cffa_req_if.sink    req_chan,
   cffa_rsp_if.source  rsp_chan,
   cffa_csr_if.sink    csr_chan
);

   localparam int IDX_W = (MAX_BLOCKS > 1) ? $clog2(MAX_BLOCKS) : 1;
   localparam int CNT_W = $clog2(MAX_BLOCKS + 1);
   localparam int CMP_W = (CNT_W > cffa_pkg::BC_W) ? CNT_W : cffa_pkg::BC_W;
   localparam int SW    = cffa_pkg::SIZE_W;
   localparam int BW    = cffa_pkg::BS_W;

   cffa_pkg::state_type state_ff, state_in;

   logic [BW-1:0]                     bs_cfg_ff, bs_cfg_in;
   logic [cffa_pkg::BC_W-1:0]         bc_cfg_ff, bc_cfg_in;
   logic [BW-1:0]                     bs_ff, bs_in;
   logic [CNT_W-1:0]                  limit_ff, limit_in;
   logic [SW-1:0]                     dvd_ff, dvd_in;
   logic [BW-1:0]                     rem_ff, rem_in;
   logic [cffa_pkg::DIV_CNT_W-1:0]    div_cnt_ff, div_cnt_in;
   logic [SW-1:0]                     need_ff, need_in;
   logic [CNT_W-1:0]                  run_ff, run_in;
   logic [IDX_W-1:0]                  scan_idx_ff, scan_idx_in;
   logic                              issue_done_ff, issue_done_in;
   logic                              chk_vld_ff, chk_vld_in;
   logic [IDX_W-1:0]                  chk_idx_ff, chk_idx_in;
   logic                              found_ff, found_in;
   logic [IDX_W-1:0]                  start_ff, start_in;
   logic [IDX_W-1:0]                  mark_addr_ff, mark_addr_in;
   logic [CNT_W-1:0]                  mark_left_ff, mark_left_in;
   logic [IDX_W-1:0]                  clr_addr_ff, clr_addr_in;
   logic                              rsp_valid_ff, rsp_valid_in;
   logic                              rsp_status_ff, rsp_status_in;
   logic [cffa_pkg::START_W-1:0]      rsp_start_ff, rsp_start_in;
   logic [SW-1:0]                     rsp_need_ff, rsp_need_in;

   logic                              used_map_ff [MAX_BLOCKS];
   logic                              rd_data_ff;

   logic                              req_ready;
   logic                              req_take;
   logic                              wr_en;
   logic [IDX_W-1:0]                  wr_addr;
   logic                              wr_data;
   logic [IDX_W-1:0]                  rd_addr;
   logic                              scan_issue;
   logic                              load_rsp;

   logic [BW:0]                       rem_sh;
   logic [BW:0]                       rem_sub;
   logic                              div_ge;
   logic [SW-1:0]                     need_calc;
   logic                              need_reject;
   logic [CNT_W-1:0]                  run_inc;
   logic                              hit;
   logic                              miss_end;
   logic [CNT_W-1:0]                  start_calc;
   logic [CMP_W-1:0]                  bc_ext;

   assign req_take = req_chan.valid && req_ready;

   assign rem_sh  = {rem_ff, dvd_ff[SW-1]};
   assign rem_sub = rem_sh - {1'b0, bs_ff};
   assign div_ge  = (rem_sh >= {1'b0, bs_ff});

   assign need_calc   = dvd_ff + SW'(rem_ff != '0);
   assign need_reject = (need_calc == '0) || (need_calc > SW'(limit_ff));

   assign run_inc    = run_ff + CNT_W'(1);
   assign hit        = (state_ff == cffa_pkg::ST_SCAN) && chk_vld_ff && !rd_data_ff &&
                       (run_inc == CNT_W'(need_ff));
   assign miss_end   = (state_ff == cffa_pkg::ST_SCAN) && chk_vld_ff && !hit &&
                       (CNT_W'(chk_idx_ff) == (limit_ff - CNT_W'(1)));
   assign start_calc = CNT_W'(chk_idx_ff) + CNT_W'(1) - run_inc;
   assign bc_ext     = CMP_W'(bc_cfg_ff);

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         cffa_pkg::ST_CLEAR: begin
            if (clr_addr_ff == IDX_W'(MAX_BLOCKS - 1)) begin
               state_in = cffa_pkg::ST_IDLE;
            end
         end
         cffa_pkg::ST_IDLE: begin
            if (req_take) begin
               state_in = cffa_pkg::ST_DIV;
            end
         end
         cffa_pkg::ST_DIV: begin
            if (div_cnt_ff == cffa_pkg::DIV_CNT_W'(SW - 1)) begin
               state_in = cffa_pkg::ST_NEED;
            end
         end
         cffa_pkg::ST_NEED: begin
            state_in = need_reject ? cffa_pkg::ST_RESULT : cffa_pkg::ST_SCAN;
         end
         cffa_pkg::ST_SCAN: begin
            if (hit) begin
               state_in = cffa_pkg::ST_MARK;
            end else if (miss_end) begin
               state_in = cffa_pkg::ST_RESULT;
            end
         end
         cffa_pkg::ST_MARK: begin
            if (mark_left_ff == CNT_W'(1)) begin
               state_in = cffa_pkg::ST_RESULT;
            end
         end
         cffa_pkg::ST_RESULT: begin
            if (load_rsp) begin
               state_in = cffa_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = cffa_pkg::ST_IDLE;
         end
      endcase
   end

   always_comb begin
      req_ready  = 1'b0;
      wr_en      = 1'b0;
      wr_addr    = mark_addr_ff;
      wr_data    = 1'b1;
      rd_addr    = scan_idx_ff;
      scan_issue = 1'b0;
      load_rsp   = 1'b0;
      case (state_ff)
         cffa_pkg::ST_CLEAR: begin
            wr_en   = 1'b1;
            wr_addr = clr_addr_ff;
            wr_data = 1'b0;
         end
         cffa_pkg::ST_IDLE: begin
            req_ready = 1'b1;
         end
         cffa_pkg::ST_SCAN: begin
            scan_issue = !issue_done_ff;
         end
         cffa_pkg::ST_MARK: begin
            wr_en = 1'b1;
         end
         cffa_pkg::ST_RESULT: begin
            load_rsp = !rsp_valid_ff || rsp_chan.ready;
         end
         default: begin
            req_ready = 1'b0;
         end
      endcase
   end

   always_comb begin
      bs_cfg_in     = bs_cfg_ff;
      bc_cfg_in     = bc_cfg_ff;
      bs_in         = bs_ff;
      limit_in      = limit_ff;
      dvd_in        = dvd_ff;
      rem_in        = rem_ff;
      div_cnt_in    = div_cnt_ff;
      need_in       = need_ff;
      run_in        = run_ff;
      scan_idx_in   = scan_idx_ff;
      issue_done_in = issue_done_ff;
      chk_vld_in    = scan_issue;
      chk_idx_in    = scan_idx_ff;
      found_in      = found_ff;
      start_in      = start_ff;
      mark_addr_in  = mark_addr_ff;
      mark_left_in  = mark_left_ff;
      clr_addr_in   = clr_addr_ff;
      rsp_status_in = rsp_status_ff;
      rsp_start_in  = rsp_start_ff;
      rsp_need_in   = rsp_need_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_chan.ready;

      if (csr_chan.valid) begin
         if (csr_chan.index == cffa_pkg::CSR_BLOCK_SIZE) begin
            bs_cfg_in = csr_chan.data[BW-1:0];
         end else if (csr_chan.index == cffa_pkg::CSR_BLOCK_COUNT) begin
            bc_cfg_in = csr_chan.data[cffa_pkg::BC_W-1:0];
         end
      end

      case (state_ff)
         cffa_pkg::ST_CLEAR: begin
            clr_addr_in = clr_addr_ff + IDX_W'(1);
         end
         cffa_pkg::ST_IDLE: begin
            if (req_take) begin
               dvd_in     = req_chan.file_size;
               rem_in     = '0;
               div_cnt_in = '0;
               bs_in      = (bs_cfg_ff == '0) ? BW'(1) : bs_cfg_ff;
               limit_in   = (bc_ext > CMP_W'(MAX_BLOCKS)) ? CNT_W'(MAX_BLOCKS)
                                                          : CNT_W'(bc_cfg_ff);
            end
         end
         cffa_pkg::ST_DIV: begin
            dvd_in     = {dvd_ff[SW-2:0], div_ge};
            rem_in     = div_ge ? rem_sub[BW-1:0] : rem_sh[BW-1:0];
            div_cnt_in = div_cnt_ff + cffa_pkg::DIV_CNT_W'(1);
         end
         cffa_pkg::ST_NEED: begin
            need_in       = need_calc;
            found_in      = (need_calc == '0);
            start_in      = '0;
            run_in        = '0;
            scan_idx_in   = '0;
            issue_done_in = 1'b0;
         end
         cffa_pkg::ST_SCAN: begin
            if (scan_issue) begin
               if (CNT_W'(scan_idx_ff) == (limit_ff - CNT_W'(1))) begin
                  issue_done_in = 1'b1;
               end else begin
                  scan_idx_in = scan_idx_ff + IDX_W'(1);
               end
            end
            if (chk_vld_ff) begin
               run_in = rd_data_ff ? '0 : run_inc;
            end
            if (hit) begin
               found_in     = 1'b1;
               start_in     = IDX_W'(start_calc);
               mark_addr_in = IDX_W'(start_calc);
               mark_left_in = run_inc;
            end
         end
         cffa_pkg::ST_MARK: begin
            mark_addr_in = mark_addr_ff + IDX_W'(1);
            mark_left_in = mark_left_ff - CNT_W'(1);
         end
         cffa_pkg::ST_RESULT: begin
            if (load_rsp) begin
               rsp_valid_in  = 1'b1;
               rsp_status_in = !found_ff;
               rsp_start_in  = cffa_pkg::START_W'(start_ff);
               rsp_need_in   = need_ff;
            end
         end
         default: begin
            clr_addr_in = clr_addr_ff;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= cffa_pkg::ST_CLEAR;
         clr_addr_ff   <= '0;
         bs_cfg_ff     <= cffa_pkg::BLOCK_SIZE_RST;
         bc_cfg_ff     <= cffa_pkg::BLOCK_COUNT_RST;
         div_cnt_ff    <= '0;
         issue_done_ff <= 1'b0;
         chk_vld_ff    <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         clr_addr_ff   <= clr_addr_in;
         bs_cfg_ff     <= bs_cfg_in;
         bc_cfg_ff     <= bc_cfg_in;
         div_cnt_ff    <= div_cnt_in;
         issue_done_ff <= issue_done_in;
         chk_vld_ff    <= chk_vld_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      bs_ff         <= bs_in;
      limit_ff      <= limit_in;
      dvd_ff        <= dvd_in;
      rem_ff        <= rem_in;
      need_ff       <= need_in;
      run_ff        <= run_in;
      scan_idx_ff   <= scan_idx_in;
      chk_idx_ff    <= chk_idx_in;
      found_ff      <= found_in;
      start_ff      <= start_in;
      mark_addr_ff  <= mark_addr_in;
      mark_left_ff  <= mark_left_in;
      rsp_status_ff <= rsp_status_in;
      rsp_start_ff  <= rsp_start_in;
      rsp_need_ff   <= rsp_need_in;
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         used_map_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= used_map_ff[rd_addr];
   end

   assign req_chan.ready         = req_ready;
   assign csr_chan.ready         = 1'b1;
   assign rsp_chan.valid         = rsp_valid_ff;
   assign rsp_chan.status        = rsp_status_ff;
   assign rsp_chan.start_block   = rsp_start_ff;
   assign rsp_chan.blocks_needed = rsp_need_ff;

`include "contiguous_first_fit_allocator_unit_assert.svh"

   `CFFA_ASSERT_NEXT(a_rem_below_divisor,
      (state_ff == cffa_pkg::ST_DIV) && (div_cnt_ff == cffa_pkg::DIV_CNT_W'(SW - 1)),
      rem_ff < bs_ff)

   `CFFA_ASSERT_NOW(a_run_below_need,
      state_ff == cffa_pkg::ST_SCAN,
      run_ff < CNT_W'(need_ff))

   `CFFA_ASSERT_NOW(a_grant_within_limit,
      load_rsp && found_ff,
      (SW'(start_ff) + need_ff) <= SW'(limit_ff))

endmodule

`default_nettype wire
